// ===== design/bhpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bhpq_pkg;

	localparam int DEPTH_DEF    = 256;
	localparam int KEY_BITS_DEF = 32;
	localparam int TAG_BITS_DEF = 16;

	// request codes
	localparam logic [1:0] REQ_PUSH   = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;

	// answer status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// result kinds
	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_ANSWER = 1'b1;

	// configuration register indexes
	localparam logic REG_ORDER_MODE = 1'b0;
	localparam logic REG_REPORT_POS = 1'b1;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] entry_key;
		logic [15:0] entry_tag;
		logic [7:0]  slot_index;
	} req_t;

	typedef struct packed {
		logic        report_kind;
		logic [1:0]  status;
		logic [31:0] out_key;
		logic [15:0] out_tag;
		logic [7:0]  out_position;
		logic [8:0]  entry_count;
		logic        last;
	} rsp_t;

endpackage
`default_nettype wire

// ===== design/bhpq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bhpq_ram #(
	parameter int AW = 8,
	parameter int DW = 48
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [(1 << AW)];

	// write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== design/binary_heap_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Handshake           Payload
// in       in   in_valid/in_stall   bhpq_pkg::req_t (request beat)
// out      out  out_valid/out_stall bhpq_pkg::rsp_t (report or answer beat)
// cfg      in   wr_en               wr_index, wr_data
//
// One request at a time; entries live in a one-port-read, one-port-write RAM.
// Read: the slot is read, then answered. Push: the entry is written at the end and
// climbs while better than its parent. Remove: the last entry moves into the slot
// and climbs or descends. A level costs up to two RAM reads and two writes.
// Reset clears the sequencer, fill count, out valid and config; no clearing pass of the RAM.
// A stalled out beat holds the sequencer at its next report or answer.
module binary_heap_priority_queue #(
	parameter int DEPTH    = bhpq_pkg::DEPTH_DEF,
	parameter int KEY_BITS = bhpq_pkg::KEY_BITS_DEF,
	parameter int TAG_BITS = bhpq_pkg::TAG_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire bhpq_pkg::req_t  in_data,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output bhpq_pkg::rsp_t       out_data,
	input  wire logic            wr_en,
	input  wire logic            wr_index,
	input  wire logic            wr_data
);
	import bhpq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > 8) ? CW : 8;
	localparam int DW = KEY_BITS + TAG_BITS;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RM_A = 4'd1;
	localparam logic [3:0] S_RM_B = 4'd2;
	localparam logic [3:0] S_RD_A = 4'd3;
	localparam logic [3:0] S_PUT  = 4'd4;
	localparam logic [3:0] S_UP_R = 4'd5;
	localparam logic [3:0] S_UP_C = 4'd6;
	localparam logic [3:0] S_SW1  = 4'd7;
	localparam logic [3:0] S_SW2  = 4'd8;
	localparam logic [3:0] S_DN_R = 4'd9;
	localparam logic [3:0] S_DN_1 = 4'd10;
	localparam logic [3:0] S_DN_2 = 4'd11;
	localparam logic [3:0] S_DN_C = 4'd12;
	localparam logic [3:0] S_ANS  = 4'd13;

	logic [3:0]          state_q;
	logic [CW-1:0]       fill_q;
	logic                order_q, report_q;
	logic                is_rm_q, first_q, dn_q;
	logic [KEY_BITS-1:0] cur_key_q, oth_key_q;
	logic [TAG_BITS-1:0] cur_tag_q, oth_tag_q;
	logic [AW-1:0]       cur_idx_q, oth_idx_q;
	logic [1:0]          ans_st_q;
	logic [KEY_BITS-1:0] ans_key_q;
	logic [TAG_BITS-1:0] ans_tag_q;
	logic                out_valid_q;
	rsp_t                out_q;

	logic                mem_we;
	logic [AW-1:0]       mem_waddr, mem_raddr;
	logic [DW-1:0]       mem_wdata, mem_rdata;
	logic [KEY_BITS-1:0] rd_key;
	logic [TAG_BITS-1:0] rd_tag;

	logic                out_free, go, emit;
	rsp_t                emit_beat;
	logic                in_acc;
	logic [PW-1:0]       pos_w, fill_w;
	logic [CW:0]         c_w, c1_w, fill_x;
	logic [AW-1:0]       par_idx;

	function automatic logic better(input logic mode, input logic [KEY_BITS-1:0] a,
			input logic [KEY_BITS-1:0] b);
		better = mode ? (a > b) : (a < b);
	endfunction

	bhpq_ram #(.AW(AW), .DW(DW)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign rd_key = mem_rdata[DW-1:TAG_BITS];
	assign rd_tag = mem_rdata[TAG_BITS-1:0];

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign go        = out_free || !report_q;

	assign pos_w   = PW'(in_data.slot_index);
	assign fill_w  = PW'(fill_q);
	assign c_w     = (CW + 1)'({cur_idx_q, 1'b1});
	assign c1_w    = c_w + 1'b1;
	assign fill_x  = (CW + 1)'(fill_q);
	assign par_idx = (cur_idx_q - 1'b1) >> 1;

	// pick the RAM read address for the next cycle
	always_comb begin
		mem_raddr = AW'(in_data.slot_index);
		case (state_q)
			S_RM_A:  mem_raddr = AW'(fill_q);
			S_UP_R:  mem_raddr = par_idx;
			S_DN_R:  mem_raddr = AW'(c_w);
			S_DN_1:  mem_raddr = AW'(c1_w);
			default: mem_raddr = AW'(in_data.slot_index);
		endcase
	end

	// slot writes and their position reports
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_idx_q;
		mem_wdata = {cur_key_q, cur_tag_q};
		emit      = 1'b0;
		emit_beat = '0;
		emit_beat.entry_count = 9'(fill_q);
		case (state_q)
			S_PUT, S_SW2: begin
				mem_we = go;
				emit   = go && report_q;
				emit_beat.report_kind  = KIND_REPORT;
				emit_beat.out_key      = 32'(cur_key_q);
				emit_beat.out_tag      = 16'(cur_tag_q);
				emit_beat.out_position = 8'(cur_idx_q);
			end
			S_SW1: begin
				mem_we    = go;
				mem_wdata = {oth_key_q, oth_tag_q};
				emit      = go && report_q;
				emit_beat.report_kind  = KIND_REPORT;
				emit_beat.out_key      = 32'(oth_key_q);
				emit_beat.out_tag      = 16'(oth_tag_q);
				emit_beat.out_position = 8'(cur_idx_q);
			end
			S_ANS: begin
				emit = out_free;
				emit_beat.report_kind = KIND_ANSWER;
				emit_beat.status      = ans_st_q;
				emit_beat.out_key     = 32'(ans_key_q);
				emit_beat.out_tag     = 16'(ans_tag_q);
				emit_beat.last        = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// hold the out beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_beat;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q  <= 1'b0;
			report_q <= 1'b1;
		end else if (wr_en) begin
			case (wr_index)
				REG_ORDER_MODE: order_q  <= wr_data;
				REG_REPORT_POS: report_q <= wr_data;
				default:        order_q  <= order_q;
			endcase
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			is_rm_q <= 1'b0;
			first_q <= 1'b0;
			dn_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						is_rm_q <= 1'b0;
						first_q <= 1'b1;
						dn_q    <= 1'b0;
						case (in_data.req_type)
							REQ_PUSH: begin
								if (fill_x == (CW + 1)'(DEPTH)) begin
									state_q <= S_ANS;
								end else begin
									fill_q  <= fill_q + 1'b1;
									state_q <= S_PUT;
								end
							end
							REQ_REMOVE: begin
								if (pos_w < fill_w) begin
									fill_q  <= fill_q - 1'b1;
									is_rm_q <= 1'b1;
									state_q <= S_RM_A;
								end else begin
									state_q <= S_ANS;
								end
							end
							REQ_READ: state_q <= (pos_w < fill_w) ? S_RD_A : S_ANS;
							default:  state_q <= S_ANS;
						endcase
					end
				end
				S_RM_A: state_q <= (cur_idx_q == AW'(fill_q)) ? S_ANS : S_RM_B;
				S_RM_B: state_q <= S_PUT;
				S_RD_A: state_q <= S_ANS;
				S_PUT:  if (go) state_q <= S_UP_R;
				S_UP_R: begin
					if (cur_idx_q != '0) begin
						state_q <= S_UP_C;
					end else if (is_rm_q && first_q) begin
						dn_q    <= 1'b1;
						state_q <= S_DN_R;
					end else begin
						state_q <= S_ANS;
					end
				end
				S_UP_C: begin
					if (better(order_q, cur_key_q, rd_key)) begin
						state_q <= S_SW1;
					end else if (is_rm_q && first_q) begin
						dn_q    <= 1'b1;
						state_q <= S_DN_R;
					end else begin
						state_q <= S_ANS;
					end
				end
				S_SW1: begin
					if (go) begin
						first_q <= 1'b0;
						state_q <= S_SW2;
					end
				end
				S_SW2:  if (go) state_q <= dn_q ? S_DN_R : S_UP_R;
				S_DN_R: state_q <= (c_w < fill_x) ? S_DN_1 : S_ANS;
				S_DN_1: state_q <= (c1_w < fill_x) ? S_DN_2 : S_DN_C;
				S_DN_2: state_q <= S_DN_C;
				S_DN_C: state_q <= better(order_q, oth_key_q, cur_key_q) ? S_SW1 : S_ANS;
				S_ANS:  if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// moving entry, partner entry and answer payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cur_key_q <= KEY_BITS'(in_data.entry_key);
				cur_tag_q <= TAG_BITS'(in_data.entry_tag);
				ans_key_q <= KEY_BITS'(in_data.entry_key);
				ans_tag_q <= TAG_BITS'(in_data.entry_tag);
				ans_st_q  <= ST_OK;
				if (in_data.req_type == REQ_PUSH) begin
					cur_idx_q <= AW'(fill_q);
					if (fill_x == (CW + 1)'(DEPTH)) begin
						ans_st_q  <= ST_FULL;
						ans_key_q <= '0;
						ans_tag_q <= '0;
					end
				end else begin
					cur_idx_q <= AW'(in_data.slot_index);
					if (in_data.req_type == REQ_PUSH || in_data.req_type == REQ_REMOVE
							|| in_data.req_type == REQ_READ) begin
						if (!(pos_w < fill_w)) begin
							ans_st_q  <= ST_RANGE;
							ans_key_q <= '0;
							ans_tag_q <= '0;
						end
					end else begin
						ans_st_q  <= ST_RANGE;
						ans_key_q <= '0;
						ans_tag_q <= '0;
					end
				end
			end
			S_RM_A, S_RD_A: begin
				ans_key_q <= rd_key;
				ans_tag_q <= rd_tag;
			end
			S_RM_B: begin
				cur_key_q <= rd_key;
				cur_tag_q <= rd_tag;
			end
			S_UP_C: begin
				oth_key_q <= rd_key;
				oth_tag_q <= rd_tag;
				oth_idx_q <= par_idx;
			end
			S_SW1: if (go) cur_idx_q <= oth_idx_q;
			S_DN_1: begin
				oth_key_q <= rd_key;
				oth_tag_q <= rd_tag;
				oth_idx_q <= AW'(c_w);
			end
			S_DN_2: begin
				if (better(order_q, rd_key, oth_key_q)) begin
					oth_key_q <= rd_key;
					oth_tag_q <= rd_tag;
					oth_idx_q <= AW'(c1_w);
				end
			end
			default: begin
				cur_idx_q <= cur_idx_q;
			end
		endcase
	end

	// fill count never passes the capacity
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_x <= (CW + 1)'(DEPTH))
		else $error("fill count above capacity");

	// the RAM is written only while a request is in work
	a_we_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q != S_IDLE))
		else $error("slot write while idle");

	// an answer beat returns the sequencer to idle
	a_ans_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_beat.last) |=> (state_q == S_IDLE))
		else $error("answer without return to idle");

	// a push that fits grows the fill count by one
	a_push_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_acc && in_data.req_type == REQ_PUSH
			&& fill_x != (CW + 1)'(DEPTH)) |=> (fill_q == $past(fill_q) + 1'b1))
		else $error("push did not grow fill count");

endmodule
`default_nettype wire
